FILE: rtl/assert_macros.svh
// Assertion macros of the nonce replay filter RTL, included by its top level.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nonce replay filter assertion failed");

// Next-cycle implication, disabled while reset is low.
`define NRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nonce replay filter assertion failed");

`endif

FILE: rtl/nrf_pkg.sv
// Package of the nonce replay filter: field widths, defaults, state codes and
// the control struct of the compare unit. Depends on nothing.
`timescale 1ns / 1ps

package nrf_pkg;

  // Width of one nonce and of the reported entry count.
  localparam int NONCE_W       = 32;
  localparam int COUNT_W       = 6;
  // Default number of remembered nonces.
  localparam int DEFAULT_DEPTH = 32;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } nrf_state_t;

  // Control of the shared compare unit.
  typedef struct packed {
    logic clr;  // Start of a new item: drop the previous hit.
    logic en;   // Read data of the store is valid this cycle.
  } cmp_ctl_t;

endpackage

FILE: rtl/nrf_store.sv
// Nonce store of the replay filter: one write port, one registered read port.
// Depends on nrf_pkg for the nonce width.
`timescale 1ns / 1ps

module nrf_store #(
  parameter int DEPTH  = nrf_pkg::DEFAULT_DEPTH,
  parameter int ADDR_W = 5
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [nrf_pkg::NONCE_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [nrf_pkg::NONCE_W-1:0] rdata
);
  import nrf_pkg::*;

  logic [NONCE_W-1:0] mem [DEPTH];
  logic [NONCE_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/nrf_cmp.sv
// Shared compare unit of the replay filter: one 32-bit equality compare per
// cycle, folded into a sticky hit flag. Depends on nrf_pkg.
`timescale 1ns / 1ps

module nrf_cmp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nrf_pkg::cmp_ctl_t           ctl,
  input  logic [nrf_pkg::NONCE_W-1:0] key,
  input  logic [nrf_pkg::NONCE_W-1:0] entry,
  output logic                        hit
);
  import nrf_pkg::*;

  logic hit_r;
  logic hit_nxt;

  // Clear on a new item, otherwise collect every match of valid read data.
  always_comb begin
    hit_nxt = hit_r;
    if (ctl.clr) begin
      hit_nxt = 1'b0;
    end else if (ctl.en && (entry == key)) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

FILE: rtl/nonce_replay_filter.sv
// Top level of the nonce replay filter: sequencer, ring pointers and result
// register. Depends on nrf_pkg, nrf_store, nrf_cmp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// A nonce transfer is taken at a rising edge where start is high and busy is
// low; in_nonce is sampled at that edge. The block checks the nonce against
// every nonce it holds (up to DEPTH, the most recent ones). On a match it
// reports out_replay = 1 and keeps the store as it is; otherwise it stores
// the nonce, evicting the oldest one when full, and reports out_replay = 0.
// out_stored_count gives the low 6 bits of the number of held nonces after
// the item. The result sits on the out_ ports for one cycle with out_valid
// high; the receiver must take it then, as it cannot stall the block.
// Steps: the block reads each held nonce in turn (ST_SCAN), waits for the
// last read data (ST_DRAIN), then stores a new nonce and registers the
// result (ST_FINISH); busy is high in all three. The single read port of
// the store paces the scan, one entry per cycle to the shared comparator.
// A new start may be given in the cycle where out_valid is high.
// Reset (rst_n low, synchronous) empties the store and returns to idle; the
// store needs no clearing pass, as only written entries are ever read.
module nonce_replay_filter #(
  parameter int DEPTH = nrf_pkg::DEFAULT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [nrf_pkg::NONCE_W-1:0] in_nonce,
  output logic                        out_valid,
  output logic                        out_replay,
  output logic [nrf_pkg::COUNT_W-1:0] out_stored_count
);
  import nrf_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  nrf_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   idx_inc;
  logic [ADDR_W-1:0]  wp_r, wp_nxt;
  logic [NONCE_W-1:0] nonce_r;
  logic               rd_pend_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_replay_r, out_replay_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  logic               accept;
  logic               mem_we;
  logic               mem_re;
  logic [NONCE_W-1:0] mem_rdata;
  logic               hit;
  cmp_ctl_t           cmp_ctl;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign idx_inc = idx_r + CNT_W'(1);

  // Read one held entry per cycle while scanning; write the nonce when new.
  assign mem_re = (state_r == ST_SCAN);
  assign mem_we = (state_r == ST_FINISH) && !hit;

  // Sequencer, ring pointers and result values.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    wp_nxt         = wp_r;
    out_valid_nxt  = 1'b0;
    out_replay_nxt = out_replay_r;
    out_count_nxt  = out_count_r;
    count_ext      = {{COUNT_W{1'b0}}, count_r};
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          idx_nxt   = '0;
          state_nxt = (count_r == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_inc;
        if (idx_inc == count_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!hit) begin
          wp_nxt = (wp_r == ADDR_W'(DEPTH - 1)) ? '0 : wp_r + ADDR_W'(1);
          if (count_r != CNT_W'(DEPTH)) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        count_ext      = {{COUNT_W{1'b0}}, count_nxt};
        out_valid_nxt  = 1'b1;
        out_replay_nxt = hit;
        out_count_nxt  = count_ext[COUNT_W-1:0];
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      wp_r        <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      wp_r        <= wp_nxt;
      rd_pend_r   <= mem_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      nonce_r <= in_nonce;
    end
    out_replay_r <= out_replay_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Store of held nonces; the valid entries are always slots 0 to count-1.
  nrf_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata (nonce_r),
    .re    (mem_re),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  // Shared comparator fed by the registered read data.
  assign cmp_ctl.clr = accept;
  assign cmp_ctl.en  = rd_pend_r;

  nrf_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cmp_ctl),
    .key   (nonce_r),
    .entry (mem_rdata),
    .hit   (hit)
  );

  assign out_valid        = out_valid_r;
  assign out_replay       = out_replay_r;
  assign out_stored_count = out_count_r;

  // Checks on the sequencer and the entry count.
  `NRF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `NRF_ASSERT_NEXT(a_finish_strobe, clk, rst_n, state_r == ST_FINISH, out_valid_r)
  `NRF_ASSERT_NEXT(a_replay_keeps, clk, rst_n, (state_r == ST_FINISH) && hit, $stable(count_r))
  `NRF_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for nonce_replay_filter: drives nonces, predicts the
// replay verdict and entry count, and checks every result.
// Depends on nrf_pkg and the nonce_replay_filter RTL.
`timescale 1ns / 1ps

module tb;

  import nrf_pkg::*;

  localparam int DEPTH          = DEFAULT_DEPTH;
  localparam int RANDOM_ITEMS   = 1850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 45;
  localparam int EVICT_KEEP     = 16;
  localparam int N_DIRECTED     = 23;

  // One verdict of the filter as it appears on the result ports.
  typedef struct packed {
    logic               replay;
    logic [COUNT_W-1:0] count;
  } verdict_t;

  // One row of the directed stimulus; typed rows carry their own verdict.
  typedef struct packed {
    logic [NONCE_W-1:0] nonce;
    logic               typed;
    logic               replay;
    logic [COUNT_W-1:0] count;
  } nonce_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [NONCE_W-1:0] in_nonce;
  logic               out_valid;
  logic               out_replay;
  logic [COUNT_W-1:0] out_stored_count;

  // Model of the window, newest nonce first, and of recently evicted nonces.
  logic [NONCE_W-1:0] window_q[$];
  logic [NONCE_W-1:0] evicted_q[$];
  verdict_t           pending_verdicts[$];
  nonce_row_t         directed_rows[0:N_DIRECTED-1];

  int unsigned error_count;
  int unsigned stall_cycles;

  nonce_replay_filter #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_nonce(in_nonce),
    .out_valid(out_valid),
    .out_replay(out_replay),
    .out_stored_count(out_stored_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Screen one nonce against the window and update it as the block would.
  function automatic verdict_t screen_nonce(input logic [NONCE_W-1:0] value);
    verdict_t v;
    bit       hit;
    hit = 1'b0;
    foreach (window_q[i]) begin
      if (window_q[i] == value) hit = 1'b1;
    end
    if (!hit) begin
      window_q.push_front(value);
      if (window_q.size() > DEPTH) begin
        evicted_q.push_back(window_q.pop_back());
        if (evicted_q.size() > EVICT_KEEP) void'(evicted_q.pop_front());
      end
    end
    v.replay = hit;
    v.count  = COUNT_W'(window_q.size());
    return v;
  endfunction

  // Pick a random nonce, weighted toward replays of held and evicted values.
  function automatic logic [NONCE_W-1:0] pick_nonce();
    int unsigned        roll;
    int unsigned        bitpos;
    logic [NONCE_W-1:0] value;
    roll   = $urandom_range(0, 99);
    bitpos = $urandom_range(0, NONCE_W - 1);
    value  = $urandom;
    if (roll < 35) begin
      value = $urandom;
    end else if (roll < 60) begin
      // Replay of a held entry; the oldest one gets extra weight.
      if (window_q.size() > 0) begin
        if ($urandom_range(0, 1) == 0) value = window_q[window_q.size() - 1];
        else value = window_q[$urandom_range(0, window_q.size() - 1)];
      end
    end else if (roll < 75) begin
      // A nonce that has already dropped out of the window must be accepted.
      if (evicted_q.size() > 0) value = evicted_q[$urandom_range(0, evicted_q.size() - 1)];
    end else if (roll < 90) begin
      value = $urandom_range(0, 63);
    end else begin
      value = '0;
      value[bitpos] = 1'b1;
      if ($urandom_range(0, 1) == 0) value = ~value;
    end
    return value;
  endfunction

  // Offer one nonce and hold it until the block takes the transfer.
  task automatic send_nonce(input nonce_row_t row);
    verdict_t v;
    in_nonce <= row.nonce;
    start    <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    v = screen_nonce(row.nonce);
    if (row.typed) begin
      v.replay = row.replay;
      v.count  = row.count;
    end
    pending_verdicts.push_back(v);
  endtask

  // Leave the input idle for a while, with noise on the nonce port.
  task automatic idle_input(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) begin
      in_nonce <= $urandom;
      @(posedge clk);
    end
  endtask

  // Sender: reset, directed rows, then the random part.
  initial begin
    nonce_row_t  row;
    bit          quiet;
    directed_rows = '{
      '{32'h0000_0000, 1'b1, 1'b0, 6'd1},
      '{32'h0000_0000, 1'b1, 1'b1, 6'd1},
      '{32'hFFFF_FFFF, 1'b1, 1'b0, 6'd2},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 6'd2},
      '{32'h0000_0001, 1'b1, 1'b0, 6'd3},
      '{32'h8000_0000, 1'b1, 1'b0, 6'd4},
      '{32'h7FFF_FFFF, 1'b1, 1'b0, 6'd5},
      '{32'h0000_0000, 1'b1, 1'b1, 6'd5},
      '{32'hFFFF_FFFE, 1'b1, 1'b0, 6'd6},
      '{32'hAAAA_AAAA, 1'b1, 1'b0, 6'd7},
      '{32'h5555_5555, 1'b1, 1'b0, 6'd8},
      '{32'h5555_5555, 1'b1, 1'b1, 6'd8},
      '{32'h0000_0001, 1'b1, 1'b1, 6'd8},
      '{32'h1234_5678, 1'b0, 1'b0, 6'd0},
      '{32'hDEAD_BEEF, 1'b0, 1'b0, 6'd0},
      '{32'hFFFF_0000, 1'b0, 1'b0, 6'd0},
      '{32'h0000_FFFF, 1'b0, 1'b0, 6'd0},
      '{32'h8000_0001, 1'b0, 1'b0, 6'd0},
      '{32'hDEAD_BEEF, 1'b0, 1'b0, 6'd0},
      '{32'h0F0F_0F0F, 1'b0, 1'b0, 6'd0},
      '{32'hF0F0_F0F0, 1'b0, 1'b0, 6'd0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 6'd0},
      '{32'h0000_0002, 1'b0, 1'b0, 6'd0}
    };
    error_count = 0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_nonce <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_nonce(directed_rows[i]);
      if ($urandom_range(0, 99) < 21) idle_input($urandom_range(1, MAX_GAP));
    end

    // Random items; one long stretch runs back to back.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      row.nonce  = pick_nonce();
      row.typed  = 1'b0;
      row.replay = 1'b0;
      row.count  = '0;
      send_nonce(row);
      quiet = (i >= 600) && (i < 900);
      if (!quiet && $urandom_range(0, 99) < 21) idle_input($urandom_range(1, MAX_GAP));
    end
    start <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DEPTH + 5) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Receiver: every result transfer is checked against the oldest verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: replay %0b stored_count %0d", out_replay,
               out_stored_count);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_replay !== want.replay) begin
          $error("replay: expected %0b, actual %0b", want.replay, out_replay);
          error_count++;
        end
        if (out_stored_count !== want.count) begin
          $error("stored_count: expected %0d, actual %0d", want.count, out_stored_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transfer happens on either side.
  always @(posedge clk) begin
    if (!rst_n || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/nrf_pkg.sv
rtl/nrf_store.sv
rtl/nrf_cmp.sv
rtl/nonce_replay_filter.sv
tb/sv/tb.sv
